FILE: src/virtual_channel_allocator_core_defines.svh
// assertion helpers for the virtual-channel allocator
`ifndef VIRTUAL_CHANNEL_ALLOCATOR_CORE_DEFINES_SVH
`define VIRTUAL_CHANNEL_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define VCA_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vca same-cycle check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define VCA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vca next-cycle check failed");

`endif

FILE: src/vca_pkg.sv
package vca_pkg;

    // default build size
    localparam int DEF_PORTS = 5;
    localparam int DEF_VCS   = 4;

    // field widths of a transfer
    localparam int OP_W    = 2;
    localparam int PORT_W  = 3;
    localparam int VC_W    = 2;
    localparam int COUNT_W = 6;

    // operation codes
    localparam logic [OP_W-1:0] OP_REQUEST  = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOCATE = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE  = 2'd2;
    localparam logic [OP_W-1:0] OP_TRANSFER = 2'd3;

    // result kinds
    localparam logic KIND_ACK   = 1'b0;
    localparam logic KIND_ALLOC = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [PORT_W-1:0] dest_port;
        logic [VC_W-1:0]   out_vc;
        logic [PORT_W-1:0] in_port;
        logic [VC_W-1:0]   in_vc;
        logic [PORT_W-1:0] new_in_port;
        logic [VC_W-1:0]   new_in_vc;
    } vca_in_t;

    typedef struct packed {
        logic               result_kind;
        logic               accepted;
        logic [COUNT_W-1:0] requester_count;
        logic               grant_valid;
        logic [PORT_W-1:0]  grant_dest_port;
        logic [VC_W-1:0]    grant_out_vc;
        logic [PORT_W-1:0]  grant_in_port;
        logic [VC_W-1:0]    grant_in_vc;
        logic               last;
    } vca_out_t;

endpackage

FILE: src/virtual_channel_allocator_core.sv
// channel   direction   payload     transfer when
// in        sink        vca_in_t    in_valid high, in_stall low
// out       source      vca_out_t   out_valid high, out_stall low
//
// request: the requester count adds one input-port group per cycle
// allocate: one output VC per cycle through the shared arbiter, unless a stalled output holds a grant
// release and transfer: no result
// a stalled output holds the sequencer wherever it must hand over a result
// reset clears request valid bits, owner valid bits and pointers and sets free bits at once
`include "virtual_channel_allocator_core_defines.svh"

module virtual_channel_allocator_core #(
    parameter int PORTS = vca_pkg::DEF_PORTS,
    parameter int VCS   = vca_pkg::DEF_VCS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  vca_pkg::vca_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output vca_pkg::vca_out_t out_data
);
    import vca_pkg::*;

    localparam int SLOTS = PORTS * VCS;
    localparam int PW    = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int VW    = (VCS > 1) ? $clog2(VCS) : 1;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [PORT_W:0] PORTS_L = (PORT_W + 1)'(PORTS);
    localparam logic [VC_W:0]   VCS_L   = (VC_W + 1)'(VCS);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_COUNT  = 3'd2;
    localparam logic [2:0] S_ACK    = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_FLUSH  = 3'd5;

    logic [2:0]             state_reg, state_next;
    vca_in_t                item_reg, item_next;
    logic [SLOTS-1:0]       valid_row_reg [PORTS];
    logic [SLOTS-1:0]       valid_row_next [PORTS];
    logic [SLOTS*VC_W-1:0]  vc_row_reg [PORTS];
    logic [SLOTS*VC_W-1:0]  vc_row_next [PORTS];
    logic                   free_reg [PORTS][VCS];
    logic                   free_next [PORTS][VCS];
    logic [SW-1:0]          rr_reg [PORTS][VCS];
    logic [SW-1:0]          rr_next [PORTS][VCS];
    logic                   own_valid_reg [PORTS][VCS];
    logic                   own_valid_next [PORTS][VCS];
    logic [PW-1:0]          own_port_reg [PORTS][VCS];
    logic [PW-1:0]          own_port_next [PORTS][VCS];
    logic [VW-1:0]          own_vc_reg [PORTS][VCS];
    logic [VW-1:0]          own_vc_next [PORTS][VCS];
    logic [PW-1:0]          scan_port_reg, scan_port_next;
    logic [VW-1:0]          scan_vc_reg, scan_vc_next;
    logic [PW-1:0]          grp_reg, grp_next;
    logic [COUNT_W-1:0]     cnt_reg, cnt_next;
    logic                   acc_reg, acc_next;
    logic                   pend_valid_reg, pend_valid_next;
    vca_out_t               pend_reg, pend_next;
    logic                   out_valid_reg, out_valid_next;
    vca_out_t               out_reg, out_next;

    logic                   out_free;
    logic                   out_load;
    vca_out_t               out_load_data;
    logic                   base_ok;
    logic                   new_ok;
    logic [PW-1:0]          op_port;
    logic [VW-1:0]          op_vc;
    logic [PW-1:0]          ip_idx;
    logic [VW-1:0]          iv_idx;
    logic [PW-1:0]          np_idx;
    logic [VW-1:0]          nv_idx;
    logic [SW-1:0]          old_slot;
    logic [SW-1:0]          new_slot;
    logic [PW-1:0]          row_addr;
    logic [SLOTS-1:0]       row_valid;
    logic [SLOTS*VC_W-1:0]  row_vc;
    logic [COUNT_W-1:0]     grp_count;
    logic [SW-1:0]          start;
    logic                   hi_found, lo_found, found;
    logic [SW-1:0]          hi_slot, lo_slot, win_slot;
    logic [PW-1:0]          hi_port, lo_port, win_port;
    logic [VW-1:0]          hi_vc, lo_vc, win_vc;
    logic                   cur_free;
    vca_out_t               grant;

    // handshake outputs
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // decoded item fields
    assign base_ok = ({1'b0, item_reg.dest_port} < PORTS_L)
                  && ({1'b0, item_reg.out_vc} < VCS_L)
                  && ({1'b0, item_reg.in_port} < PORTS_L) && ({1'b0, item_reg.in_vc} < VCS_L);
    assign new_ok  = ({1'b0, item_reg.new_in_port} < PORTS_L)
                  && ({1'b0, item_reg.new_in_vc} < VCS_L);
    assign op_port  = item_reg.dest_port[PW-1:0];
    assign op_vc    = item_reg.out_vc[VW-1:0];
    assign ip_idx   = item_reg.in_port[PW-1:0];
    assign iv_idx   = item_reg.in_vc[VW-1:0];
    assign np_idx   = item_reg.new_in_port[PW-1:0];
    assign nv_idx   = item_reg.new_in_vc[VW-1:0];
    assign old_slot = SW'(int'(ip_idx) * VCS + int'(iv_idx));
    assign new_slot = SW'(int'(np_idx) * VCS + int'(nv_idx));

    // single row read port shared by count and scan
    assign row_addr  = (state_reg == S_SCAN) ? scan_port_reg : op_port;
    assign row_valid = valid_row_reg[row_addr];
    assign row_vc    = vc_row_reg[row_addr];

    // requester count over one input-port group
    always_comb
    begin
        grp_count = '0;
        for (int i = 0; i < VCS; i++)
        begin
            grp_count = grp_count + COUNT_W'(row_valid[SW'(int'(grp_reg) * VCS + i)]);
        end
    end

    // shared round-robin arbiter, lowest slot at or after the pointer wins, else lowest
    assign start    = rr_reg[scan_port_reg][scan_vc_reg];
    assign cur_free = free_reg[scan_port_reg][scan_vc_reg];

    always_comb
    begin
        hi_found = 1'b0;
        lo_found = 1'b0;
        hi_slot  = '0;
        lo_slot  = '0;
        hi_port  = '0;
        lo_port  = '0;
        hi_vc    = '0;
        lo_vc    = '0;
        for (int pi = PORTS - 1; pi >= 0; pi--)
        begin
            for (int vi = VCS - 1; vi >= 0; vi--)
            begin
                if (row_valid[pi * VCS + vi]
                    && row_vc[(pi * VCS + vi) * VC_W +: VC_W] == VC_W'(scan_vc_reg))
                begin
                    lo_found = 1'b1;
                    lo_slot  = SW'(pi * VCS + vi);
                    lo_port  = PW'(pi);
                    lo_vc    = VW'(vi);
                    if (SW'(pi * VCS + vi) >= start)
                    begin
                        hi_found = 1'b1;
                        hi_slot  = SW'(pi * VCS + vi);
                        hi_port  = PW'(pi);
                        hi_vc    = VW'(vi);
                    end
                end
            end
        end
    end

    assign found    = cur_free && (hi_found || lo_found);
    assign win_slot = hi_found ? hi_slot : lo_slot;
    assign win_port = hi_found ? hi_port : lo_port;
    assign win_vc   = hi_found ? hi_vc : lo_vc;

    // grant result for the output VC under scan
    always_comb
    begin
        grant                 = '0;
        grant.result_kind     = KIND_ALLOC;
        grant.grant_valid     = 1'b1;
        grant.grant_dest_port = PORT_W'(scan_port_reg);
        grant.grant_out_vc    = VC_W'(scan_vc_reg);
        grant.grant_in_port   = PORT_W'(win_port);
        grant.grant_in_vc     = VC_W'(win_vc);
    end

    // sequencer and table updates
    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        valid_row_next  = valid_row_reg;
        vc_row_next     = vc_row_reg;
        free_next       = free_reg;
        rr_next         = rr_reg;
        own_valid_next  = own_valid_reg;
        own_port_next   = own_port_reg;
        own_vc_next     = own_vc_reg;
        scan_port_next  = scan_port_reg;
        scan_vc_next    = scan_vc_reg;
        grp_next        = grp_reg;
        cnt_next        = cnt_reg;
        acc_next        = acc_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_load        = 1'b0;
        out_load_data   = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                state_next = S_IDLE;
                case (item_reg.op)
                    OP_REQUEST:
                    begin
                        cnt_next = '0;
                        grp_next = '0;
                        if (!base_ok)
                        begin
                            acc_next   = 1'b0;
                            state_next = S_ACK;
                        end
                        else
                        begin
                            // an existing entry keeps its wanted VC
                            if (!valid_row_reg[op_port][old_slot])
                            begin
                                valid_row_next[op_port][old_slot] = 1'b1;
                                vc_row_next[op_port][old_slot * VC_W +: VC_W] = item_reg.out_vc;
                            end
                            acc_next   = 1'b1;
                            state_next = S_COUNT;
                        end
                    end

                    OP_ALLOCATE:
                    begin
                        scan_port_next  = '0;
                        scan_vc_next    = '0;
                        pend_valid_next = 1'b0;
                        state_next      = S_SCAN;
                    end

                    OP_RELEASE:
                    begin
                        if (base_ok)
                        begin
                            valid_row_next[op_port][old_slot] = 1'b0;
                            if (own_valid_reg[op_port][op_vc]
                                && own_port_reg[op_port][op_vc] == ip_idx
                                && own_vc_reg[op_port][op_vc] == iv_idx)
                            begin
                                own_valid_next[op_port][op_vc] = 1'b0;
                            end
                            free_next[op_port][op_vc] = 1'b1;
                        end
                    end

                    OP_TRANSFER:
                    begin
                        // clear first so a transfer onto itself stays valid
                        if (base_ok && new_ok)
                        begin
                            valid_row_next[op_port][old_slot] = 1'b0;
                            valid_row_next[op_port][new_slot] = 1'b1;
                            vc_row_next[op_port][new_slot * VC_W +: VC_W] = item_reg.out_vc;
                            own_valid_next[op_port][op_vc] = 1'b1;
                            own_port_next[op_port][op_vc]  = np_idx;
                            own_vc_next[op_port][op_vc]    = nv_idx;
                        end
                    end

                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_COUNT:
            begin
                cnt_next = cnt_reg + grp_count;
                if (grp_reg == PW'(PORTS - 1))
                begin
                    state_next = S_ACK;
                end
                else
                begin
                    grp_next = grp_reg + 1'b1;
                end
            end

            S_ACK:
            begin
                if (out_free)
                begin
                    out_load                      = 1'b1;
                    out_load_data.result_kind     = KIND_ACK;
                    out_load_data.accepted        = acc_reg;
                    out_load_data.requester_count = cnt_reg;
                    out_load_data.last            = 1'b1;
                    state_next                    = S_IDLE;
                end
            end

            S_SCAN:
            begin
                // a held grant must leave before a new one takes its place
                if (!(found && pend_valid_reg) || out_free)
                begin
                    if (found)
                    begin
                        rr_next[scan_port_reg][scan_vc_reg]        = win_slot;
                        free_next[scan_port_reg][scan_vc_reg]      = 1'b0;
                        own_valid_next[scan_port_reg][scan_vc_reg] = 1'b1;
                        own_port_next[scan_port_reg][scan_vc_reg]  = win_port;
                        own_vc_next[scan_port_reg][scan_vc_reg]    = win_vc;
                        if (pend_valid_reg)
                        begin
                            out_load      = 1'b1;
                            out_load_data = pend_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = grant;
                    end
                    if (scan_vc_reg == VW'(VCS - 1))
                    begin
                        scan_vc_next = '0;
                        if (scan_port_reg == PW'(PORTS - 1))
                        begin
                            state_next = S_FLUSH;
                        end
                        else
                        begin
                            scan_port_next = scan_port_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        scan_vc_next = scan_vc_reg + 1'b1;
                    end
                end
            end

            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_load_data = pend_reg;
                    end
                    else
                    begin
                        out_load_data.result_kind = KIND_ALLOC;
                    end
                    out_load_data.last = 1'b1;
                    pend_valid_next    = 1'b0;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_next       = out_load_data;
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state and tables with a reset value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            scan_port_reg  <= '0;
            scan_vc_reg    <= '0;
            grp_reg        <= '0;
            cnt_reg        <= '0;
            acc_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int p = 0; p < PORTS; p++)
            begin
                valid_row_reg[p] <= '0;
                for (int v = 0; v < VCS; v++)
                begin
                    free_reg[p][v]      <= 1'b1;
                    rr_reg[p][v]        <= '0;
                    own_valid_reg[p][v] <= 1'b0;
                end
            end
        end
        else
        begin
            state_reg      <= state_next;
            scan_port_reg  <= scan_port_next;
            scan_vc_reg    <= scan_vc_next;
            grp_reg        <= grp_next;
            cnt_reg        <= cnt_next;
            acc_reg        <= acc_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            valid_row_reg  <= valid_row_next;
            free_reg       <= free_next;
            rr_reg         <= rr_next;
            own_valid_reg  <= own_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        vc_row_reg   <= vc_row_next;
        own_port_reg <= own_port_next;
        own_vc_reg   <= own_vc_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
    end

    // checks
    `VCA_ASSERT_NOW(a_no_load_while_held, out_valid_reg && out_stall, !out_load)
    `VCA_ASSERT_NOW(a_pend_only_in_alloc, pend_valid_reg,
        state_reg == S_SCAN || state_reg == S_FLUSH)
    `VCA_ASSERT_NEXT(a_flush_ends_round, state_reg == S_FLUSH && out_free,
        out_valid_reg && out_reg.last && out_reg.result_kind == KIND_ALLOC)
    `VCA_ASSERT_NEXT(a_ack_is_final, state_reg == S_ACK && out_free,
        out_valid_reg && out_reg.last && out_reg.result_kind == KIND_ACK)

endmodule
